FILE: hw/rtl/ldr_pkg.sv
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared types, constants and helpers for the linear distribution generator.
// ----------------------------------------------------------------------------
package ldr_pkg;

   // generator constants
   localparam logic [31:0] LCG_MUL   = 32'd2891336453;
   localparam logic [31:0] LCG_ADD   = 32'd1500450271;
   localparam logic [31:0] LCG_SEED0 = 32'd1997333137;

   localparam int STATE_W = 32;
   localparam int RAND_W  = 32;

   // defaults for the top-level parameters
   localparam int RANGE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // register port
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEND_HIGH   = 1'b1;

   // square root: 64-bit radicand, two result bits per cycle
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = 32;
   localparam int REM_W       = ROOT_W + 3;
   localparam int SQRT_CYCLES = ROOT_W / 2;
   localparam int CNT_W       = $clog2(SQRT_CYCLES);

   // one LCG step, kept to 31 bits; only the low 31 bits of the state matter
   function automatic logic [30:0] lcg_next(input logic [STATE_W-1:0] s);
      logic [61:0] p;
      p = s[30:0] * LCG_MUL[30:0];
      return 31'(p[30:0] + LCG_ADD[30:0]);
   endfunction

   localparam logic [30:0] GEN_RESET = lcg_next(LCG_SEED0);

   typedef struct packed {
      logic accept_seed;
      logic accept_draw;
      logic root_init;
      logic root_step;
      logic multiply;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic root_last;
   } status_type;

endpackage

FILE: hw/rtl/linear_distribution_random.sv
// ----------------------------------------------------------------------------
// linear_distribution_random
// Random source with a linear density, built on a 31-bit LCG.
//
// Request channel (req_): req_type 0 draws a value, 1 loads req_seed_value
// into the generator. Result channel (rsp_): one rsp_rand_value, unsigned
// Q16.16 below range_limit, per draw transaction; seeds give no result.
// Register port (csr_): index 0 = range_limit (0 acts as 1), index 1 =
// tend_high. Write only while no draw is in flight.
//
// A draw steps the generator when it is accepted, then loads the radicand,
// runs the square root at two root bits per cycle, multiplies by the range
// and clamps the product into the output register. A new request is taken
// only once the block is idle; seeds are taken one per cycle while it is
// idle. The output register lets a draw be accepted while the previous
// result waits; a stalled receiver holds the finished value in the clamp
// stage until the register frees up.
// Reset clears the registers to zero, empties the output and loads the
// generator with one step from its fixed seed.
// ----------------------------------------------------------------------------
module linear_distribution_random #(
   parameter int RANGE_BITS = ldr_pkg::RANGE_BITS_DEF,
   parameter int FRAC_BITS  = ldr_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [ldr_pkg::STATE_W-1:0]     req_seed_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ldr_pkg::RAND_W-1:0]      rsp_rand_value,
   input  logic                            csr_wr_en,
   input  logic [ldr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ldr_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import ldr_pkg::*;

   cmd_type    cmd;
   status_type status;

   ldr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   ldr_dp #(
      .RANGE_BITS (RANGE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_seed_value (req_seed_value),
      .rsp_rand_value (rsp_rand_value),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

FILE: hw/rtl/ldr_ctrl.sv
// ----------------------------------------------------------------------------
// ldr_ctrl
// Sequencer: accepts transactions, steps the datapath through the draw and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module ldr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ldr_pkg::cmd_type    cmd,
   input  ldr_pkg::status_type status
);
   import ldr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROOT,
      ST_MULT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type) begin
                  cmd.accept_seed = 1'b1;
               end else begin
                  cmd.accept_draw = 1'b1;
                  state_in        = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.root_init = 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.multiply = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            // hold the finished value until the output register frees up
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/ldr_dp.sv
// ----------------------------------------------------------------------------
// ldr_dp
// Datapath: generator state, registers, digit-by-digit square root, range
// multiply, clamp and the result register.
// ----------------------------------------------------------------------------
module ldr_dp #(
   parameter int RANGE_BITS = ldr_pkg::RANGE_BITS_DEF,
   parameter int FRAC_BITS  = ldr_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ldr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ldr_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic [ldr_pkg::STATE_W-1:0]      req_seed_value,
   output logic [ldr_pkg::RAND_W-1:0]       rsp_rand_value,
   input  ldr_pkg::cmd_type                 cmd,
   output ldr_pkg::status_type              status
);
   import ldr_pkg::*;

   // effective range width: the register is 16 bits, masked to RANGE_BITS
   localparam int RW     = (RANGE_BITS < CSR_DATA_W) ? RANGE_BITS : CSR_DATA_W;
   localparam int PROD_W = RW + ROOT_W;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   function automatic sq_type sq_step(input sq_type cur, input logic [1:0] pair);
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] trial;
      sq_type           nxt;
      sh    = {cur.rem[REM_W-3:0], pair};
      trial = {1'b0, cur.root, 2'b01};
      if (sh >= trial) begin
         nxt.rem  = sh - trial;
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = sh;
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic [STATE_W-1:0] gen_state_ff, gen_state_in;
   logic [CSR_DATA_W-1:0] range_ff;
   logic               tend_ff;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   sq_type             sq_ff, sq_in, sq_mid;
   logic [CNT_W-1:0]   count_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [RAND_W-1:0]  out_ff, out_in;

   logic [RW-1:0]      range_eff;
   logic [30:0]        r;
   logic [31:0]        comp;
   logic [ROOT_W-1:0]  q;
   logic               clamp;
   logic [63:0]        val64;
   logic [63:0]        cl64;

   assign range_eff = (range_ff[RW-1:0] == '0) ? RW'(1) : range_ff[RW-1:0];
   assign r         = gen_state_ff[30:0];
   assign comp      = 32'h8000_0000 - {1'b0, r};

   always_comb begin
      gen_state_in = gen_state_ff;
      if (cmd.accept_seed)      gen_state_in = req_seed_value;
      else if (cmd.accept_draw) gen_state_in = {1'b0, lcg_next(gen_state_ff)};
   end

   // radicand r*2^31 for rising density, (2^31 - r)*2^31 for falling
   always_comb begin
      rad_in = rad_ff;
      sq_in  = sq_ff;
      sq_mid = sq_step(sq_ff, rad_ff[RAD_W-1 -: 2]);
      if (cmd.root_init) begin
         rad_in = tend_ff ? {2'b00, r, 31'b0} : {1'b0, comp, 31'b0};
         sq_in  = '0;
      end else if (cmd.root_step) begin
         rad_in = rad_ff << 4;
         sq_in  = sq_step(sq_mid, rad_ff[RAD_W-3 -: 2]);
      end
   end

   assign status.root_last = (count_ff == CNT_W'(SQRT_CYCLES - 1));

   assign q       = tend_ff ? sq_ff.root : (32'h8000_0000 - sq_ff.root);
   assign prod_in = PROD_W'(range_eff) * PROD_W'(q);

   // val >= range<<FRAC is the same test as prod >= range<<31
   assign clamp  = (prod_ff >= PROD_W'({range_eff, 31'b0}));
   assign val64  = 64'(prod_ff) >> (31 - FRAC_BITS);
   assign cl64   = 64'(range_eff - RW'(1)) << FRAC_BITS;
   assign out_in = clamp ? cl64[RAND_W-1:0] : val64[RAND_W-1:0];

   assign rsp_rand_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= {1'b0, GEN_RESET};
         range_ff     <= '0;
         tend_ff      <= 1'b0;
         count_ff     <= '0;
      end else begin
         gen_state_ff <= gen_state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RANGE_LIMIT: range_ff <= csr_wr_data;
               CSR_TEND_HIGH:   tend_ff  <= csr_wr_data[0];
               default: ;
            endcase
         end
         if (cmd.root_init)      count_ff <= '0;
         else if (cmd.root_step) count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      sq_ff  <= sq_in;
      if (cmd.multiply) prod_ff <= prod_in;
      if (cmd.load_out) out_ff  <= out_in;
   end

endmodule

FILE: hw/rtl/ldr_checker.sv
// ----------------------------------------------------------------------------
// ldr_checker
// Port-level checks on the linear distribution generator.
// ----------------------------------------------------------------------------
module ldr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_type,
   input logic [ldr_pkg::STATE_W-1:0]     req_seed_value,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ldr_pkg::RAND_W-1:0]      rsp_rand_value,
   input logic                            csr_wr_en,
   input logic [ldr_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [ldr_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import ldr_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rand_value))
      else $error("result changed or dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a seed transaction never produces a result
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a seed transaction");

   // an accepted draw occupies the block: no new request and no instant result
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_type |=> !req_ready && !$rose(rsp_valid))
      else $error("draw did not occupy the block");

endmodule

bind linear_distribution_random ldr_checker u_ldr_checker (.*);

FILE: bench/ldr_test_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_test_pkg
// Request codes shared by the linear distribution bench and its predictor.
// ----------------------------------------------------------------------------
package ldr_test_pkg;

   typedef enum logic {
      REQ_DRAW = 1'b0,
      REQ_SEED = 1'b1
   } req_kind_e;

endpackage

FILE: bench/linear_draw_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_draw_predictor
// Watches the request, result and register ports of the linear distribution
// generator, keeps its own copy of the LCG and registers, predicts each drawn
// value and compares it with the results in order.
// ----------------------------------------------------------------------------
module linear_draw_predictor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_type,
   input  logic [ldr_pkg::STATE_W-1:0]     req_seed_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [ldr_pkg::RAND_W-1:0]      rsp_rand_value,
   input  logic                            csr_wr_en,
   input  logic [ldr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ldr_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                              fail_count,
   output int                              pending
);
   import ldr_test_pkg::*;

   localparam int FRAC = ldr_pkg::FRAC_BITS_DEF;

   logic [31:0] gen_state;
   logic [15:0] range_reg;
   logic        rising_reg;
   logic [31:0] expected_values[$];

   function automatic logic [30:0] lcg_step(input logic [31:0] s);
      logic [31:0] n;
      n = s * ldr_pkg::LCG_MUL + ldr_pkg::LCG_ADD;
      return n[30:0];
   endfunction

   // floor(sqrt(v)), one root bit per pass
   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      int          k;
      rem  = v;
      root = 64'd0;
      bitv = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] linear_draw(input logic [30:0] u31,
                                               input logic [15:0] lim,
                                               input logic rising);
      logic [63:0] span;
      logic [63:0] q;
      logic [63:0] scaled;
      span = (lim == 16'd0) ? 64'd1 : {48'd0, lim};
      if (rising) begin
         q = root_floor({33'd0, u31} << 31);
      end else begin
         q = (64'd1 << 31) - root_floor(((64'd1 << 31) - {33'd0, u31}) << 31);
      end
      scaled = (span * q) >> (31 - FRAC);
      if (scaled >= (span << FRAC)) begin
         scaled = (span - 64'd1) << FRAC;
      end
      return scaled[31:0];
   endfunction

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         gen_state  = {1'b0, lcg_step(ldr_pkg::LCG_SEED0)};
         range_reg  = 16'd0;
         rising_reg = 1'b0;
         expected_values.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               ldr_pkg::CSR_RANGE_LIMIT: range_reg  = csr_wr_data;
               ldr_pkg::CSR_TEND_HIGH:   rising_reg = csr_wr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_rand_value);
               fail_count++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_rand_value !== want) begin
                  $display("%0t: rand_value mismatch, expected %h, actual %h",
                           $time, want, rsp_rand_value);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == REQ_SEED) begin
               gen_state = req_seed_value;
            end else begin
               gen_state = {1'b0, lcg_step(gen_state)};
               expected_values.push_back(linear_draw(gen_state[30:0], range_reg,
                                                     rising_reg));
            end
         end
      end
      pending = expected_values.size();
   end

endmodule

FILE: bench/linear_distribution_random_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_distribution_random_test
// Drives draw and seed transactions into the linear distribution generator
// with random gaps and result stalls, across several range and slope
// settings. A directed part hits the ends of the unit interval in both
// slopes; a random part follows. The predictor module checks every result.
// ----------------------------------------------------------------------------
module linear_distribution_random_test;
   import ldr_test_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 250;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic                            req_type;
   logic [ldr_pkg::STATE_W-1:0]     req_seed_value;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [ldr_pkg::RAND_W-1:0]      rsp_rand_value;
   logic                            csr_wr_en;
   logic [ldr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ldr_pkg::CSR_DATA_W-1:0]  csr_wr_data;
   int                              fail_count;
   int                              pending;
   logic                            steady;

   linear_distribution_random uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rand_value (rsp_rand_value),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   linear_draw_predictor draw_watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rand_value (rsp_rand_value),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, a few long ones; none while steady is set
   function automatic int idle_len();
      int p;
      if (steady) return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      else if (p < 85) return $urandom_range(1, 3);
      else if (p < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // seed whose next LCG step lands exactly on target
   function automatic logic [31:0] seed_for_draw(input logic [30:0] target);
      logic [31:0] inv;
      logic [30:0] low;
      logic        top;
      inv = ldr_pkg::LCG_MUL;
      repeat (5) inv = inv * (32'd2 - ldr_pkg::LCG_MUL * inv);
      low = (target - ldr_pkg::LCG_ADD[30:0]) * inv[30:0];
      top = 1'($urandom_range(0, 1));
      return {top, low};
   endfunction

   // called and returns at a falling edge
   task automatic send_request(input req_kind_e kind, input logic [31:0] seed);
      int gap;
      gap = idle_len();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type       = kind;
      req_seed_value = seed;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      // let the block settle after the last result before the registers change
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [ldr_pkg::CSR_INDEX_W-1:0] index,
                            input logic [ldr_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = index;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // result side
   initial begin
      int idle;
      rsp_ready = 1'b0;
      forever begin
         idle = idle_len();
         if (idle != 0) begin
            rsp_ready = 1'b0;
            repeat (idle) @(negedge clock);
         end
         rsp_ready = 1'b1;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("linear_distribution_random_test failed");
      $finish;
   end

   initial begin
      int          phase;
      int          n;
      int          pick;
      logic [15:0] lim;
      logic [31:0] noise;
      reset          = 1'b1;
      steady         = 1'b0;
      req_valid      = 1'b0;
      req_type       = REQ_DRAW;
      req_seed_value = '0;
      csr_wr_en      = 1'b0;
      csr_index      = ldr_pkg::CSR_RANGE_LIMIT;
      csr_wr_data    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset registers: zero range acts as one, falling slope
      send_request(REQ_DRAW, $urandom);
      send_request(REQ_DRAW, $urandom);
      send_request(REQ_SEED, seed_for_draw(31'd0));
      send_request(REQ_DRAW, $urandom);
      send_request(REQ_SEED, seed_for_draw(31'h7fff_ffff));
      send_request(REQ_DRAW, $urandom);
      drain();

      write_reg(ldr_pkg::CSR_RANGE_LIMIT, 16'hffff);
      write_reg(ldr_pkg::CSR_TEND_HIGH, 16'd1);
      send_request(REQ_SEED, seed_for_draw(31'd0));
      send_request(REQ_DRAW, $urandom);
      send_request(REQ_SEED, seed_for_draw(31'h7fff_ffff));
      send_request(REQ_DRAW, $urandom);
      send_request(REQ_SEED, 32'hffff_ffff);
      send_request(REQ_DRAW, $urandom);
      send_request(REQ_SEED, 32'h0000_0000);
      send_request(REQ_SEED, seed_for_draw(31'd1));
      send_request(REQ_DRAW, $urandom);
      drain();

      write_reg(ldr_pkg::CSR_TEND_HIGH, 16'd0);
      send_request(REQ_SEED, seed_for_draw(31'd0));
      send_request(REQ_DRAW, $urandom);
      send_request(REQ_SEED, seed_for_draw(31'h7fff_ffff));
      send_request(REQ_DRAW, $urandom);
      send_request(REQ_SEED, seed_for_draw(31'h4000_0000));
      send_request(REQ_DRAW, $urandom);
      drain();

      write_reg(ldr_pkg::CSR_RANGE_LIMIT, 16'd1);
      write_reg(ldr_pkg::CSR_TEND_HIGH, 16'd1);
      send_request(REQ_SEED, seed_for_draw(31'h7fff_ffff));
      send_request(REQ_DRAW, $urandom);

      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case ($urandom_range(0, 5))
            0: lim = 16'd0;
            1: lim = 16'd1;
            2: lim = 16'hffff;
            3: lim = 16'hfffe;
            4: lim = 16'($urandom_range(2, 255));
            default: lim = 16'($urandom_range(0, 65535));
         endcase
         if (phase == 0) lim = 16'hffff;
         if (phase == 1) lim = 16'd0;
         write_reg(ldr_pkg::CSR_RANGE_LIMIT, lim);
         write_reg(ldr_pkg::CSR_TEND_HIGH, 16'((phase == 0) ? 1 : $urandom_range(0, 1)));
         steady = (phase % 4 == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick  = $urandom_range(0, 99);
            noise = $urandom;
            if (pick < 78) begin
               send_request(REQ_DRAW, noise);
            end else if (pick < 95) begin
               send_request(REQ_SEED, noise);
            end else begin
               case ($urandom_range(0, 2))
                  0: send_request(REQ_SEED, seed_for_draw(31'd0));
                  1: send_request(REQ_SEED, seed_for_draw(31'h7fff_ffff));
                  default: send_request(REQ_SEED, seed_for_draw(noise[30:0]));
               endcase
            end
         end
         steady = 1'b0;
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("linear_distribution_random_test passed");
      end else begin
         $display("linear_distribution_random_test failed");
      end
      $finish;
   end

endmodule
